/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

/* hdl/kzn_pkg.sv */
`timescale 1ns / 1ps
package kzn_pkg;

  localparam int CHAIN_BITS_DEF = 256;
  localparam int BLK_W = 128;
  localparam int RK_NUM = 10;
  localparam int RK_AW = 4;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] MODE_CBC_ENC = 2'd0;
  localparam logic [1:0] MODE_CBC_DEC = 2'd1;
  localparam logic [1:0] MODE_CFB_ENC = 2'd2;
  localparam logic [1:0] MODE_CFB_DEC = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_W0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_W1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_W2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_W3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IV_W0 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IV_W1 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IV_W2 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_IV_W3 = 3'd7;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        restart;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_KS_KEY0, ST_KS_KEY1, ST_KS_STEP, ST_KS_WB,
    ST_IDLE, ST_CH_RD, ST_PREP, ST_RUN, ST_FIN
  } state_t;

  typedef logic [BLK_W-1:0][BLK_W-1:0] lmat_t;

  localparam logic [7:0] LIN_COEF [16] = '{
    8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1, 8'd251,
    8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148, 8'd1};

  localparam logic [7:0] SBOX [256] = '{
    8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,
    8'd251,8'd196,8'd250,8'd218,8'd35,8'd197,8'd4,8'd77,
    8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,
    8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,
    8'd249,8'd24,8'd101,8'd90,8'd226,8'd92,8'd239,8'd33,
    8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
    8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,
    8'd6,8'd11,8'd237,8'd152,8'd127,8'd212,8'd211,8'd31,
    8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,
    8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,
    8'd181,8'd112,8'd14,8'd86,8'd8,8'd12,8'd118,8'd18,
    8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
    8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,
    8'd243,8'd145,8'd120,8'd111,8'd157,8'd158,8'd178,8'd177,
    8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,
    8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,
    8'd223,8'd245,8'd36,8'd169,8'd62,8'd168,8'd67,8'd201,
    8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
    8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,
    8'd220,8'd232,8'd40,8'd80,8'd78,8'd51,8'd10,8'd74,
    8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,
    8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,
    8'd173,8'd69,8'd70,8'd146,8'd39,8'd94,8'd85,8'd47,
    8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
    8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,
    8'd48,8'd55,8'd107,8'd228,8'd136,8'd217,8'd231,8'd137,
    8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,
    8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,
    8'd32,8'd113,8'd103,8'd164,8'd45,8'd43,8'd9,8'd91,
    8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
    8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,
    8'd209,8'd102,8'd175,8'd194,8'd57,8'd75,8'd99,8'd182};

  localparam logic [7:0] SBOX_INV [256] = '{
    8'ha5,8'h2d,8'h32,8'h8f,8'h0e,8'h30,8'h38,8'hc0,
    8'h54,8'he6,8'h9e,8'h39,8'h55,8'h7e,8'h52,8'h91,
    8'h64,8'h03,8'h57,8'h5a,8'h1c,8'h60,8'h07,8'h18,
    8'h21,8'h72,8'ha8,8'hd1,8'h29,8'hc6,8'ha4,8'h3f,
    8'he0,8'h27,8'h8d,8'h0c,8'h82,8'hea,8'hae,8'hb4,
    8'h9a,8'h63,8'h49,8'he5,8'h42,8'he4,8'h15,8'hb7,
    8'hc8,8'h06,8'h70,8'h9d,8'h41,8'h75,8'h19,8'hc9,
    8'haa,8'hfc,8'h4d,8'hbf,8'h2a,8'h73,8'h84,8'hd5,
    8'hc3,8'haf,8'h2b,8'h86,8'ha7,8'hb1,8'hb2,8'h5b,
    8'h46,8'hd3,8'h9f,8'hfd,8'hd4,8'h0f,8'h9c,8'h2f,
    8'h9b,8'h43,8'hef,8'hd9,8'h79,8'hb6,8'h53,8'h7f,
    8'hc1,8'hf0,8'h23,8'he7,8'h25,8'h5e,8'hb5,8'h1e,
    8'ha2,8'hdf,8'ha6,8'hfe,8'hac,8'h22,8'hf9,8'he2,
    8'h4a,8'hbc,8'h35,8'hca,8'hee,8'h78,8'h05,8'h6b,
    8'h51,8'he1,8'h59,8'ha3,8'hf2,8'h71,8'h56,8'h11,
    8'h6a,8'h89,8'h94,8'h65,8'h8c,8'hbb,8'h77,8'h3c,
    8'h7b,8'h28,8'hab,8'hd2,8'h31,8'hde,8'hc4,8'h5f,
    8'hcc,8'hcf,8'h76,8'h2c,8'hb8,8'hd8,8'h2e,8'h36,
    8'hdb,8'h69,8'hb3,8'h14,8'h95,8'hbe,8'h62,8'ha1,
    8'h3b,8'h16,8'h66,8'he9,8'h5c,8'h6c,8'h6d,8'had,
    8'h37,8'h61,8'h4b,8'hb9,8'he3,8'hba,8'hf1,8'ha0,
    8'h85,8'h83,8'hda,8'h47,8'hc5,8'hb0,8'h33,8'hfa,
    8'h96,8'h6f,8'h6e,8'hc2,8'hf6,8'h50,8'hff,8'h5d,
    8'ha9,8'h8e,8'h17,8'h1b,8'h97,8'h7d,8'hec,8'h58,
    8'hf7,8'h1f,8'hfb,8'h7c,8'h09,8'h0d,8'h7a,8'h67,
    8'h45,8'h87,8'hdc,8'he8,8'h4f,8'h1d,8'h4e,8'h04,
    8'heb,8'hf8,8'hf3,8'h3e,8'h3d,8'hbd,8'h8a,8'h88,
    8'hdd,8'hcd,8'h0b,8'h13,8'h98,8'h02,8'h93,8'h80,
    8'h90,8'hd0,8'h24,8'h34,8'hcb,8'hed,8'hf4,8'hce,
    8'h99,8'h10,8'h44,8'h40,8'h92,8'h3a,8'h01,8'h26,
    8'h12,8'h1a,8'h48,8'h68,8'hf5,8'h81,8'h8b,8'hc7,
    8'hd6,8'h20,8'h0a,8'h08,8'h00,8'h4c,8'hd7,8'h74};

  // GF(2^8) product, polynomial x^8+x^7+x^6+x+1.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] x;
    logic [7:0] acc;
    x = {1'b0, a};
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ x[7:0];
      x = x << 1;
      if (x[8]) x = x ^ 9'h1C3;
    end
    return acc;
  endfunction

  // Byte i of a block sits at bits 127-8i downward.
  function automatic logic [BLK_W-1:0] l_fwd_slow(input logic [BLK_W-1:0] v_in);
    logic [BLK_W-1:0] v;
    logic [7:0] s;
    v = v_in;
    for (int r = 0; r < 16; r++) begin
      s = '0;
      for (int i = 0; i < 16; i++) s = s ^ gf_mul(v[127-8*i -: 8], LIN_COEF[i]);
      v = {s, v[127:8]};
    end
    return v;
  endfunction

  function automatic logic [BLK_W-1:0] l_inv_slow(input logic [BLK_W-1:0] v_in);
    logic [BLK_W-1:0] v;
    logic [7:0] s;
    v = v_in;
    for (int r = 0; r < 16; r++) begin
      v = {v[119:0], v[127:120]};
      s = '0;
      for (int i = 0; i < 16; i++) s = s ^ gf_mul(v[127-8*i -: 8], LIN_COEF[i]);
      v = {v[127:8], s};
    end
    return v;
  endfunction

  // Column j holds the image of unit vector j; evaluated at elaboration.
  function automatic lmat_t build_lmat(input logic inverse);
    lmat_t m;
    logic [BLK_W-1:0] e;
    for (int j = 0; j < BLK_W; j++) begin
      e = '0;
      e[j] = 1'b1;
      m[j] = inverse ? l_inv_slow(e) : l_fwd_slow(e);
    end
    return m;
  endfunction

  localparam lmat_t LFWD = build_lmat(1'b0);
  localparam lmat_t LINV = build_lmat(1'b1);

  function automatic logic [BLK_W-1:0] lin_apply(input lmat_t m, input logic [BLK_W-1:0] v);
    logic [BLK_W-1:0] r;
    r = '0;
    for (int j = 0; j < BLK_W; j++) r = r ^ (m[j] & {BLK_W{v[j]}});
    return r;
  endfunction

  function automatic logic [BLK_W-1:0] s_fwd(input logic [BLK_W-1:0] v);
    logic [BLK_W-1:0] r;
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = SBOX[v[127-8*i -: 8]];
    return r;
  endfunction

  function automatic logic [BLK_W-1:0] s_inv(input logic [BLK_W-1:0] v);
    logic [BLK_W-1:0] r;
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = SBOX_INV[v[127-8*i -: 8]];
    return r;
  endfunction

  function automatic logic [BLK_W-1:0] enc_round(input logic [BLK_W-1:0] v,
                                                 input logic [BLK_W-1:0] k);
    return lin_apply(LFWD, s_fwd(v ^ k));
  endfunction

  function automatic logic [BLK_W-1:0] dec_round(input logic [BLK_W-1:0] v,
                                                 input logic [BLK_W-1:0] k);
    return s_inv(lin_apply(LINV, v ^ k));
  endfunction

endpackage

/* hdl/kzn_ram.sv */
`timescale 1ns / 1ps
module kzn_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 10,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* hdl/kuznyechik_cbc_cfb_engine.sv */
`timescale 1ns / 1ps
// Each item passes through chain read, prepare, nine rounds at one round a cycle
// through the round-key memory, a final round-key XOR, and finish.
// A new item is accepted only after the current one has finished.
// Key write or reset: round-key rebuild, no item accepted meanwhile.
// Reset: synchronous, clears key, IV and chain state (chain reads as zero IV).
module kuznyechik_cbc_cfb_engine #(
  parameter int CHAIN_BITS = kzn_pkg::CHAIN_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  kzn_pkg::in_item_t               req,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output kzn_pkg::out_item_t              rsp,
  input  logic                            cfg_we,
  input  logic [kzn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                     cfg_data
);
  import kzn_pkg::*;

  // Chain memory holds 128-bit segments used as a ring; head is the oldest.
  localparam int NSEG = CHAIN_BITS / BLK_W;
  localparam int SEG_AW = (NSEG > 1) ? $clog2(NSEG) : 1;
  localparam int CNT_W = $clog2(NSEG + 1);

  state_t state, state_next;

  logic [63:0] key_w [4];
  logic [63:0] iv_w [4];
  logic [63:0] iv_snap [4];

  logic [BLK_W-1:0] ks_a, ks_b, ks_t;
  logic [4:0]       ks_step;

  logic [1:0]       mode;
  logic [BLK_W-1:0] blk, top, v;
  logic [3:0]       rnd;

  logic [SEG_AW-1:0] head;
  logic [CNT_W-1:0]  fill_cnt;

  logic             rk_we;
  logic [RK_AW-1:0] rk_waddr, rk_raddr;
  logic [BLK_W-1:0] rk_wdata, rk_rdata;

  logic             ch_we;
  logic [BLK_W-1:0] ch_wdata, ch_rdata;

  logic [BLK_W-1:0] res, fb, fill_seg, top_sel;
  logic             key_write, accept, is_dec, last_step;

  assign key_write = cfg_we && (cfg_index inside {[REG_KEY_W0:REG_KEY_W3]});
  assign accept = req_valid && req_ready;
  assign is_dec = (mode == MODE_CBC_DEC);
  assign last_step = (ks_step[2:0] == 3'd7);

  // One key-schedule step: Feistel round with the step constant.
  assign ks_t = enc_round(ks_a, lin_apply(LFWD, {120'd0, 8'(ks_step) + 8'd1})) ^ ks_b;

  kzn_ram #(.WIDTH(BLK_W), .DEPTH(RK_NUM)) u_rk_ram (
    .clk(clk), .we(rk_we), .waddr(rk_waddr), .wdata(rk_wdata),
    .raddr(rk_raddr), .rdata(rk_rdata)
  );

  kzn_ram #(.WIDTH(BLK_W), .DEPTH(NSEG)) u_chain_ram (
    .clk(clk), .we(ch_we), .waddr(head), .wdata(ch_wdata),
    .raddr(head), .rdata(ch_rdata)
  );

  // Unwritten ring entries since the last reload read as the latched IV (entries past the second read as zero).
  always_comb begin
    if (head == SEG_AW'(0)) fill_seg = {iv_snap[0], iv_snap[1]};
    else if (head == SEG_AW'(1)) fill_seg = {iv_snap[2], iv_snap[3]};
    else fill_seg = '0;
    top_sel = (fill_cnt == CNT_W'(NSEG)) ? ch_rdata : fill_seg;
  end

  always_comb begin
    case (mode)
      MODE_CBC_ENC: begin
        res = v;
        fb = v;
      end
      MODE_CBC_DEC: begin
        res = v ^ top;
        fb = blk;
      end
      MODE_CFB_ENC: begin
        res = blk ^ v;
        fb = blk ^ v;
      end
      default: begin
        res = blk ^ v;
        fb = blk;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_KS_KEY0: state_next = ST_KS_KEY1;
      ST_KS_KEY1: state_next = ST_KS_STEP;
      ST_KS_STEP: if (last_step) state_next = ST_KS_WB;
      ST_KS_WB:   state_next = (ks_step == 5'd31) ? ST_IDLE : ST_KS_STEP;
      ST_IDLE:    if (req_valid) state_next = ST_CH_RD;
      ST_CH_RD:   state_next = ST_PREP;
      ST_PREP:    state_next = ST_RUN;
      ST_RUN:     if (rnd == 4'd9) state_next = ST_FIN;
      ST_FIN:     if (!rsp_valid || rsp_ready) state_next = ST_IDLE;
      default:    state_next = ST_KS_KEY0;
    endcase
    if (key_write) state_next = ST_KS_KEY0;
  end

  // Memory ports and handshake.
  always_comb begin
    req_ready = 1'b0;
    rk_we = 1'b0;
    rk_waddr = '0;
    rk_wdata = ks_t;
    rk_raddr = '0;
    ch_we = 1'b0;
    ch_wdata = fb;
    case (state)
      ST_KS_KEY0: begin
        rk_we = 1'b1;
        rk_wdata = {key_w[0], key_w[1]};
      end
      ST_KS_KEY1: begin
        rk_we = 1'b1;
        rk_waddr = RK_AW'(1);
        rk_wdata = ks_b;
      end
      ST_KS_STEP: begin
        rk_we = last_step;
        rk_waddr = {1'b0, ks_step[4:3], 1'b0} + RK_AW'(2);
      end
      ST_KS_WB: begin
        rk_we = 1'b1;
        rk_waddr = {1'b0, ks_step[4:3], 1'b0} + RK_AW'(3);
        rk_wdata = ks_b;
      end
      ST_IDLE:  req_ready = 1'b1;
      ST_PREP:  rk_raddr = is_dec ? RK_AW'(RK_NUM - 1) : '0;
      ST_RUN: begin
        if (rnd == 4'd9) rk_raddr = '0;
        else if (is_dec) rk_raddr = RK_AW'(8) - rnd;
        else rk_raddr = rnd + RK_AW'(1);
      end
      ST_FIN:   ch_we = !rsp_valid || rsp_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_KS_KEY0;
      rsp_valid <= 1'b0;
      head <= '0;
      fill_cnt <= '0;
      for (int i = 0; i < 4; i++) begin
        key_w[i] <= '0;
        iv_w[i] <= '0;
        iv_snap[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index inside {[REG_KEY_W0:REG_KEY_W3]}) key_w[cfg_index[1:0]] <= cfg_data;
        else iv_w[cfg_index[1:0]] <= cfg_data;
      end
      // Restart: reload the ring from the IV as it stands now.
      if (accept && req.restart) begin
        head <= '0;
        fill_cnt <= '0;
        for (int i = 0; i < 4; i++) iv_snap[i] <= iv_w[i];
      end
      if (ch_we) begin
        head <= (head == SEG_AW'(NSEG - 1)) ? '0 : head + SEG_AW'(1);
        if (fill_cnt != CNT_W'(NSEG)) fill_cnt <= fill_cnt + CNT_W'(1);
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_KS_KEY0: begin
        ks_a <= {key_w[0], key_w[1]};
        ks_b <= {key_w[2], key_w[3]};
        ks_step <= '0;
      end
      ST_KS_STEP: begin
        ks_a <= ks_t;
        ks_b <= ks_a;
        if (!last_step) ks_step <= ks_step + 5'd1;
      end
      ST_KS_WB: ks_step <= ks_step + 5'd1;
      ST_IDLE: begin
        mode <= req.req_type;
        blk <= {req.block_hi, req.block_lo};
      end
      ST_PREP: begin
        top <= top_sel;
        rnd <= '0;
        case (mode)
          MODE_CBC_ENC: v <= blk ^ top_sel;
          MODE_CBC_DEC: v <= blk;
          default:      v <= top_sel;
        endcase
      end
      ST_RUN: begin
        rnd <= rnd + 4'd1;
        if (rnd == 4'd9) v <= v ^ rk_rdata;
        else if (is_dec) v <= dec_round(v, rk_rdata);
        else v <= enc_round(v, rk_rdata);
      end
      ST_FIN: if (ch_we) rsp <= {res[127:64], res[63:0]};
      default: ;
    endcase
  end

endmodule

/* hdl/kzn_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kzn_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input kzn_pkg::out_item_t rsp
);

  // A waiting result holds until taken.
  `ASSERT_CLK(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
  // One item at a time: busy right after an accept.
  `ASSERT_CLK(a_busy_after_accept, clk, rst, req_valid && req_ready |=> !req_ready)
  // Reset starts the key rebuild with nothing to deliver.
  `ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !req_ready && !rsp_valid)

endmodule

bind kuznyechik_cbc_cfb_engine kzn_checker u_kzn_checker (
  .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready),
  .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);
